// ===== design/cartridge_bank_mapper_scanline_irq_defines.svh =====
// ---------------------------------------------------------------------------
// Cartridge mapper assertion macros
// Shared assertion forms for the cartridge mapper RTL.
// ---------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CBMSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CBMSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cbmsi_pkg.sv =====
// ---------------------------------------------------------------------------
// Cartridge mapper package
// Types, codes and reset constants shared by the mapper modules.
// ---------------------------------------------------------------------------
package cbmsi_pkg;

   // Default bank-count limits.
   localparam int PRG_BANK_BITS_MAX_DEF = 6;
   localparam int CHR_BANK_BITS_MAX_DEF = 8;

   // Event codes.
   localparam logic [2:0] OP_CPU_RD   = 3'd0;
   localparam logic [2:0] OP_CPU_WR   = 3'd1;
   localparam logic [2:0] OP_PPU_RD   = 3'd2;
   localparam logic [2:0] OP_PPU_WR   = 3'd3;
   localparam logic [2:0] OP_SCANLINE = 3'd4;

   // Target memory codes.
   localparam logic [1:0] TGT_NONE    = 2'd0;
   localparam logic [1:0] TGT_PRG_ROM = 2'd1;
   localparam logic [1:0] TGT_PRG_RAM = 2'd2;
   localparam logic [1:0] TGT_CHR     = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PRG_BANK_BITS      = 3'd0;
   localparam logic [2:0] CSR_CHR_BANK_BITS      = 3'd1;
   localparam logic [2:0] CSR_HAS_WORK_RAM       = 3'd2;
   localparam logic [2:0] CSR_CHR_WRITABLE       = 3'd3;
   localparam logic [2:0] CSR_INITIAL_HORIZONTAL = 3'd4;

   // Address map.
   localparam logic [15:0] CPU_RAM_BASE = 16'h6000;
   localparam logic [15:0] CPU_ROM_BASE = 16'h8000;
   localparam logic [15:0] PPU_CHR_TOP  = 16'h2000;

   // Register write regions within 0x8000-0xFFFF, from address bits 14:13.
   localparam logic [1:0] REG_BANK   = 2'd0;
   localparam logic [1:0] REG_MIRROR = 2'd1;
   localparam logic [1:0] REG_IRQ    = 2'd2;
   localparam logic [1:0] REG_ENABLE = 2'd3;

   // Reset values.
   localparam logic [2:0]      PRG_BANK_BITS_RESET = 3'd5;
   localparam logic [3:0]      CHR_BANK_BITS_RESET = 4'd8;
   localparam logic [7:0]      RAM_PROTECT_RESET   = 8'h80;
   localparam logic [7:0][7:0] BANK_REGS_RESET     =
      {8'd1, 8'd0, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
   } cbmsi_req_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [18:0] mem_offset;
      logic        mem_write;
      logic        irq_out;
      logic        mirror_horizontal;
   } cbmsi_rsp_type;

   // Mapper state that the address translation looks at.
   typedef struct packed {
      logic [7:0]      bank_ctrl;
      logic [7:0][7:0] bank_regs;
      logic [7:0]      ram_protect;
      logic [2:0]      prg_bank_bits;
      logic [3:0]      chr_bank_bits;
      logic            has_work_ram;
      logic            chr_writable;
   } xlate_state_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [18:0] mem_offset;
      logic        mem_write;
   } xlate_result_type;

endpackage

// ===== design/cbmsi_xlate.sv =====
// ---------------------------------------------------------------------------
// Cartridge mapper address translation
// Maps one bus event onto a target memory, byte offset and write strobe.
// ---------------------------------------------------------------------------
module cbmsi_xlate import cbmsi_pkg::*; #(
   parameter int MAX_PRG_BANK_BITS = PRG_BANK_BITS_MAX_DEF,
   parameter int MAX_CHR_BANK_BITS = CHR_BANK_BITS_MAX_DEF
) (
   input  logic [2:0]       opcode,
   input  logic [15:0]      bus_address,
   input  xlate_state_type  cur_state,
   output xlate_result_type result
);

   localparam int PB = MAX_PRG_BANK_BITS;
   localparam int CB = MAX_CHR_BANK_BITS;

   logic [3:0]    prg_bits_eff;
   logic [3:0]    chr_bits_eff;
   logic [PB-1:0] prg_mask;
   logic [CB-1:0] chr_mask;
   logic [PB-1:0] prg_pick;
   logic [PB-1:0] prg_bank;
   logic [31:0]   prg_off_wide;
   logic [12:0]   chr_a;
   logic [2:0]    chr_idx;
   logic [7:0]    chr_reg;
   logic [7:0]    chr_raw;
   logic [CB-1:0] chr_bank;
   logic [10:0]   chr_low;
   logic [31:0]   chr_off_wide;
   logic          ram_on;
   logic          in_ram;
   logic          in_rom;
   logic          in_chr;

   // Bank counts saturate at the supported maximum.
   always_comb begin
      prg_bits_eff = (4'(cur_state.prg_bank_bits) > 4'(PB)) ? 4'(PB)
                                                            : 4'(cur_state.prg_bank_bits);
      chr_bits_eff = (cur_state.chr_bank_bits > 4'(CB)) ? 4'(CB) : cur_state.chr_bank_bits;
      for (int i = 0; i < PB; i++) begin
         prg_mask[i] = (4'(i) < prg_bits_eff);
      end
      for (int i = 0; i < CB; i++) begin
         chr_mask[i] = (4'(i) < chr_bits_eff);
      end
   end

   // PRG banking: the last bank is fixed, the second to last swaps with R6.
   always_comb begin
      unique case (bus_address[14:13])
         2'd0: begin
            prg_pick = cur_state.bank_ctrl[6] ? (prg_mask & ~PB'(1))
                                              : cur_state.bank_regs[6][PB-1:0];
         end
         2'd1: begin
            prg_pick = cur_state.bank_regs[7][PB-1:0];
         end
         2'd2: begin
            prg_pick = cur_state.bank_ctrl[6] ? cur_state.bank_regs[6][PB-1:0]
                                              : (prg_mask & ~PB'(1));
         end
         default: begin
            prg_pick = prg_mask;
         end
      endcase
      prg_bank     = prg_pick & prg_mask;
      prg_off_wide = {{(32 - PB - 13){1'b0}}, prg_bank, bus_address[12:0]};
   end

   // CHR banking: two 2KB banks in one half and four 1KB banks in the other.
   always_comb begin
      chr_a        = bus_address[12:0] ^ {cur_state.bank_ctrl[7], 12'b0};
      chr_idx      = chr_a[12] ? (3'd2 + {1'b0, chr_a[11:10]}) : {2'b00, chr_a[11]};
      chr_reg      = cur_state.bank_regs[chr_idx];
      chr_raw      = chr_a[12] ? chr_reg : {chr_reg[7:1], 1'b0};
      chr_bank     = chr_raw[CB-1:0] & chr_mask;
      chr_low      = chr_a[12] ? {1'b0, chr_a[9:0]} : chr_a[10:0];
      chr_off_wide = {{(32 - CB - 10){1'b0}}, chr_bank, 10'b0} + {21'b0, chr_low};
   end

   always_comb begin
      ram_on = cur_state.has_work_ram & cur_state.ram_protect[7];
      in_ram = (bus_address >= CPU_RAM_BASE) && (bus_address < CPU_ROM_BASE);
      in_rom = (bus_address >= CPU_ROM_BASE);
      in_chr = (bus_address < PPU_CHR_TOP);

      result.target     = TGT_NONE;
      result.mem_offset = '0;
      result.mem_write  = 1'b0;

      unique case (opcode)
         OP_CPU_RD: begin
            if (in_ram && ram_on) begin
               result.target     = TGT_PRG_RAM;
               result.mem_offset = {6'b0, bus_address[12:0]};
            end else if (in_rom) begin
               result.target     = TGT_PRG_ROM;
               result.mem_offset = prg_off_wide[18:0];
            end
         end
         OP_CPU_WR: begin
            if (in_ram && ram_on && !cur_state.ram_protect[6]) begin
               result.target     = TGT_PRG_RAM;
               result.mem_offset = {6'b0, bus_address[12:0]};
               result.mem_write  = 1'b1;
            end
         end
         OP_PPU_RD: begin
            if (in_chr) begin
               result.target     = TGT_CHR;
               result.mem_offset = chr_off_wide[18:0];
            end
         end
         OP_PPU_WR: begin
            if (in_chr && cur_state.chr_writable) begin
               result.target     = TGT_CHR;
               result.mem_offset = chr_off_wide[18:0];
               result.mem_write  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/cartridge_bank_mapper_scanline_irq.sv =====
// ---------------------------------------------------------------------------
// Cartridge bank mapper with scanline IRQ counter
// Register decode, bank translation and scanline interrupt for one cartridge.
// ---------------------------------------------------------------------------
// Usage: each req beat carries one bus event (CPU read or write, PPU read or
// write, or one filtered A12 scanline clock). Each event gives exactly one rsp
// beat with the target memory, byte offset, write strobe, the IRQ level and
// the mirroring after the event. The csr channel sets the cartridge geometry;
// it is always ready and must be written only while no events are in flight;
// the block does not enforce this. The event is captured in an input register
// at acceptance and its result is then registered in the output register.
// Throughput is one event per cycle while rsp_stall is low; the mapper state
// updates as an event moves from the input register to the output register,
// so the next event always sees the state left by the one before it.
// When rsp_stall is high the output register holds its beat and the input
// register holds its event; req_stall rises only when both are full, so one
// more event is still taken while a finished result waits.
// Synchronous reset restores all configuration and mapper state to the
// power-on values, with mirroring vertical. A write to initial_horizontal is
// accepted but, since reset also returns it to vertical, never shows.
// ---------------------------------------------------------------------------
module cartridge_bank_mapper_scanline_irq import cbmsi_pkg::*; #(
   parameter int MAX_PRG_BANK_BITS = PRG_BANK_BITS_MAX_DEF,
   parameter int MAX_CHR_BANK_BITS = CHR_BANK_BITS_MAX_DEF
) (
   input  logic          clock,
   input  logic          reset,
   // Event channel.
   input  logic          req_valid,
   output logic          req_stall,
   input  cbmsi_req_type req_item,
   // Result channel.
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output cbmsi_rsp_type rsp_item,
   // Configuration write channel.
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [3:0]    csr_wdata
);

`include "cartridge_bank_mapper_scanline_irq_defines.svh"

   // Pipeline registers.
   logic          s1_valid_ff;
   cbmsi_req_type s1_item_ff;
   logic          rsp_valid_ff;
   cbmsi_rsp_type rsp_item_ff;
   cbmsi_rsp_type rsp_item_in;
   logic          out_free;
   logic          s1_move;

   // Configuration.
   logic [2:0] prg_bank_bits_ff;
   logic [3:0] chr_bank_bits_ff;
   logic       has_work_ram_ff;
   logic       chr_writable_ff;

   // Mapper state and its next values.
   logic [7:0]      bank_ctrl_ff, bank_ctrl_in;
   logic [7:0][7:0] bank_regs_ff, bank_regs_in;
   logic            mirroring_ff, mirroring_in;
   logic [7:0]      ram_protect_ff, ram_protect_in;
   logic [7:0]      irq_latch_ff, irq_latch_in;
   logic [7:0]      irq_count_ff, irq_count_in;
   logic            irq_reload_ff, irq_reload_in;
   logic            irq_enable_ff, irq_enable_in;
   logic            irq_pending_ff, irq_pending_in;

   xlate_state_type  xl_state;
   xlate_result_type xl_result;

   // The output register frees when empty or when its beat is taken. The
   // input register advances whenever the output register can take it.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Configuration writes. The initial mirroring register has no effect
   // until a reset, and reset itself restores it to vertical, so it is not
   // kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bank_bits_ff <= PRG_BANK_BITS_RESET;
         chr_bank_bits_ff <= CHR_BANK_BITS_RESET;
         has_work_ram_ff  <= 1'b1;
         chr_writable_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PRG_BANK_BITS: begin
               prg_bank_bits_ff <= csr_wdata[2:0];
            end
            CSR_CHR_BANK_BITS: begin
               chr_bank_bits_ff <= csr_wdata;
            end
            CSR_HAS_WORK_RAM: begin
               has_work_ram_ff <= csr_wdata[0];
            end
            CSR_CHR_WRITABLE: begin
               chr_writable_ff <= csr_wdata[0];
            end
            CSR_INITIAL_HORIZONTAL: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      xl_state.bank_ctrl     = bank_ctrl_ff;
      xl_state.bank_regs     = bank_regs_ff;
      xl_state.ram_protect   = ram_protect_ff;
      xl_state.prg_bank_bits = prg_bank_bits_ff;
      xl_state.chr_bank_bits = chr_bank_bits_ff;
      xl_state.has_work_ram  = has_work_ram_ff;
      xl_state.chr_writable  = chr_writable_ff;
   end

   cbmsi_xlate #(
      .MAX_PRG_BANK_BITS (MAX_PRG_BANK_BITS),
      .MAX_CHR_BANK_BITS (MAX_CHR_BANK_BITS)
   ) u_xlate (
      .opcode      (s1_item_ff.opcode),
      .bus_address (s1_item_ff.bus_address),
      .cur_state   (xl_state),
      .result      (xl_result)
   );

   // Register writes and the scanline counter. State changes only when the
   // event in the input register moves on to the output register.
   always_comb begin
      bank_ctrl_in   = bank_ctrl_ff;
      bank_regs_in   = bank_regs_ff;
      mirroring_in   = mirroring_ff;
      ram_protect_in = ram_protect_ff;
      irq_latch_in   = irq_latch_ff;
      irq_count_in   = irq_count_ff;
      irq_reload_in  = irq_reload_ff;
      irq_enable_in  = irq_enable_ff;
      irq_pending_in = irq_pending_ff;

      if (s1_move) begin
         unique case (s1_item_ff.opcode)
            OP_CPU_WR: begin
               if (s1_item_ff.bus_address >= CPU_ROM_BASE) begin
                  // Even addresses pick the first register of each pair.
                  unique case (s1_item_ff.bus_address[14:13])
                     REG_BANK: begin
                        if (!s1_item_ff.bus_address[0]) begin
                           bank_ctrl_in = s1_item_ff.write_data;
                        end else begin
                           bank_regs_in[bank_ctrl_ff[2:0]] = s1_item_ff.write_data;
                        end
                     end
                     REG_MIRROR: begin
                        if (!s1_item_ff.bus_address[0]) begin
                           mirroring_in = s1_item_ff.write_data[0];
                        end else begin
                           ram_protect_in = s1_item_ff.write_data;
                        end
                     end
                     REG_IRQ: begin
                        if (!s1_item_ff.bus_address[0]) begin
                           irq_latch_in = s1_item_ff.write_data;
                        end else begin
                           irq_count_in  = 8'd0;
                           irq_reload_in = 1'b1;
                        end
                     end
                     default: begin
                        if (!s1_item_ff.bus_address[0]) begin
                           irq_enable_in  = 1'b0;
                           irq_pending_in = 1'b0;
                        end else begin
                           irq_enable_in = 1'b1;
                        end
                     end
                  endcase
               end
            end
            OP_SCANLINE: begin
               // Reload on zero or on request, otherwise count down; an
               // enabled counter that ends at zero raises the interrupt.
               if ((irq_count_ff == 8'd0) || irq_reload_ff) begin
                  irq_count_in  = irq_latch_ff;
                  irq_reload_in = 1'b0;
               end else begin
                  irq_count_in = irq_count_ff - 8'd1;
               end
               if ((irq_count_in == 8'd0) && irq_enable_ff) begin
                  irq_pending_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_item_in.target            = xl_result.target;
      rsp_item_in.mem_offset        = xl_result.mem_offset;
      rsp_item_in.mem_write         = xl_result.mem_write;
      rsp_item_in.irq_out           = irq_pending_in;
      rsp_item_in.mirror_horizontal = mirroring_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ctrl_ff   <= 8'd0;
         bank_regs_ff   <= BANK_REGS_RESET;
         mirroring_ff   <= 1'b0;
         ram_protect_ff <= RAM_PROTECT_RESET;
         irq_latch_ff   <= 8'd0;
         irq_count_ff   <= 8'd0;
         irq_reload_ff  <= 1'b0;
         irq_enable_ff  <= 1'b0;
         irq_pending_ff <= 1'b0;
      end else begin
         bank_ctrl_ff   <= bank_ctrl_in;
         bank_regs_ff   <= bank_regs_in;
         mirroring_ff   <= mirroring_in;
         ram_protect_ff <= ram_protect_in;
         irq_latch_ff   <= irq_latch_in;
         irq_count_ff   <= irq_count_in;
         irq_reload_ff  <= irq_reload_in;
         irq_enable_ff  <= irq_enable_in;
         irq_pending_ff <= irq_pending_in;
      end
   end

   // An event held back by a stalled output must still be there next cycle.
   `CBMSI_ASSERT_NEXT(a_held_event_kept, clock, reset,
                      s1_valid_ff && !out_free, s1_valid_ff,
                      "held event was dropped")

   // An event leaving the input register always shows up as a result beat.
   `CBMSI_ASSERT_NEXT(a_move_gives_beat, clock, reset,
                      s1_move, rsp_valid_ff,
                      "moved event gave no result beat")

   // A pending interrupt clears only through reset or a CPU register write.
   `CBMSI_ASSERT_NOW(a_irq_clear_source, clock, reset,
                     $fell(irq_pending_ff),
                     $past(reset) || ($past(s1_move) &&
                                      ($past(s1_item_ff.opcode) == OP_CPU_WR)),
                     "pending interrupt cleared without a register write")

endmodule
